// File: hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Default geometry of the bitmap
  localparam int MAX_BLOCKS_DEF = 16384;
  localparam int WORD_BITS_DEF  = 32;

  // Fixed field widths
  localparam int IDX_W  = 14;           // block index, search start
  localparam int BLK_W  = 15;           // block counts, total
  localparam int BASE_W = BLK_W + 1;    // word base pointer, one bit of headroom

  // Register port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [IDX_W-1:0] SEARCH_START_RST = 14'd1024;
  localparam logic [BLK_W-1:0] TOTAL_BLOCKS_RST = 15'd16384;

  // Register indexes, taken from paddr[2]
  localparam logic REG_SEARCH_START = 1'b0;
  localparam logic REG_TOTAL_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic [IDX_W-1:0] search_start;
    logic [BLK_W-1:0] total_blocks;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/bba_bitmap_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_bitmap_ram #(
  parameter int DEPTH = bba_pkg::MAX_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF,
  parameter int WIDTH = bba_pkg::WORD_BITS_DEF,
  parameter int AW    = $clog2(bba_pkg::MAX_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/bba_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::CFG_AW-1:0]  paddr,
  input  logic [bba_pkg::CFG_DW-1:0]  pwdata,
  output logic [bba_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output bba_pkg::cfg_t               cfg,
  output logic                        total_wr
);

  import bba_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_beat;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt  = cfg_r;
    total_wr = 1'b0;
    if (wr_beat) begin
      case (reg_sel)
        REG_SEARCH_START: begin
          cfg_nxt.search_start = pwdata[IDX_W-1:0];
        end
        REG_TOTAL_BLOCKS: begin
          cfg_nxt.total_blocks = pwdata[BLK_W-1:0];
          total_wr             = 1'b1;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SEARCH_START: prdata = CFG_DW'(cfg_r.search_start);
      REG_TOTAL_BLOCKS: prdata = CFG_DW'(cfg_r.total_blocks);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_start <= SEARCH_START_RST;
      cfg_r.total_blocks <= TOTAL_BLOCKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hw/rtl/bba_word_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_word_eval #(
  parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]           word,
  input  logic [bba_pkg::BASE_W-1:0]     base,
  input  logic [bba_pkg::BASE_W-1:0]     lo_bound,
  input  logic [bba_pkg::BASE_W-1:0]     hi_bound,
  output logic                           found,
  output logic [$clog2(WORD_BITS)-1:0]   first_pos,
  output logic [$clog2(WORD_BITS+1)-1:0] set_count
);

  import bba_pkg::*;

  localparam int WB_LOG = $clog2(WORD_BITS);
  localparam int PC_W   = $clog2(WORD_BITS + 1);
  localparam logic [BASE_W-1:0] WORD_SPAN = BASE_W'(WORD_BITS);
  localparam logic [WB_LOG:0]   WORD_CNT  = (WB_LOG + 1)'(WORD_BITS);

  logic [BASE_W-1:0]    lo_diff;
  logic [BASE_W-1:0]    hi_diff;
  logic [WB_LOG:0]      lo_off;
  logic [WB_LOG:0]      hi_cnt;
  logic [WORD_BITS-1:0] in_win;
  logic [WORD_BITS-1:0] clr_bits;
  logic [WORD_BITS-1:0] set_bits;

  assign lo_diff = lo_bound - base;
  assign hi_diff = hi_bound - base;

  // window of bit positions inside [lo_bound, hi_bound)
  always_comb begin
    if (lo_bound <= base) begin
      lo_off = '0;
    end else if (lo_diff >= WORD_SPAN) begin
      lo_off = WORD_CNT;
    end else begin
      lo_off = lo_diff[WB_LOG:0];
    end
    if (hi_bound <= base) begin
      hi_cnt = '0;
    end else if (hi_diff >= WORD_SPAN) begin
      hi_cnt = WORD_CNT;
    end else begin
      hi_cnt = hi_diff[WB_LOG:0];
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      in_win[j] = ((WB_LOG + 1)'(j) >= lo_off) && ((WB_LOG + 1)'(j) < hi_cnt);
    end
  end

  assign clr_bits = ~word & in_win;
  assign set_bits = word & in_win;
  assign found    = |clr_bits;

  // lowest clear bit inside the window
  always_comb begin
    first_pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (clr_bits[j]) begin
        first_pos = WB_LOG'(j);
      end
    end
  end

  always_comb begin
    set_count = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      set_count = set_count + PC_W'(set_bits[j]);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Beat contents
// in_       sink       in_valid / in_ready    operation, block_index
// out_      source     out_valid / out_ready  status, allocated_block, free_blocks
// config    APB slave  psel/penable/pready    search_start @0x0, total_blocks @0x4
//
// Allocate reads one bitmap word a cycle through the single RAM read port while it scans.
// Reset: a clearing pass writes every bitmap word, with in_ready low;
// register writes are still taken.
// A write to total_blocks starts a recount of set bits below the new total, with
// in_ready low.
// A result held in the output register stalls in_ready until out_ready takes it; the
// next beat can be accepted on that same edge.
// WORD_BITS must be a power of two.

module bitmap_block_allocator_top #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // item channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [bba_pkg::IDX_W-1:0]  in_block_index,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [bba_pkg::IDX_W-1:0]  out_allocated_block,
  output logic [bba_pkg::BLK_W-1:0]  out_free_blocks,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bba_pkg::CFG_AW-1:0] paddr,
  input  logic [bba_pkg::CFG_DW-1:0] pwdata,
  output logic [bba_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  import bba_pkg::*;

  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WB_LOG    = $clog2(WORD_BITS);
  localparam int PC_W      = $clog2(WORD_BITS + 1);
  localparam int BLK_MAXV  = (2 ** BLK_W) - 1;

  // clamp of total_blocks to the bitmap size
  localparam logic [BLK_W-1:0]  BLK_CAP   = (MAX_BLOCKS > BLK_MAXV) ? BLK_W'(BLK_MAXV)
                                                                    : BLK_W'(MAX_BLOCKS);
  localparam logic [BASE_W-1:0] WORD_STEP = BASE_W'(WORD_BITS);
  localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_COUNT = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] word_addr(input logic [BASE_W-1:0] bit_pos);
    logic [BASE_W-1:0] shifted;
    shifted = bit_pos >> WB_LOG;
    return AW'(shifted);
  endfunction

  // registers
  cfg_t cfg;
  logic total_wr;

  // bitmap RAM
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [WORD_BITS-1:0] ram_rd_data;
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;

  // word evaluation
  logic [BASE_W-1:0]    ev_lo;
  logic                 ev_found;
  logic [WB_LOG-1:0]    ev_pos;
  logic [PC_W-1:0]      ev_count;

  // control and payload registers
  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [BASE_W-1:0]    chk_base_r, chk_base_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [BLK_W-1:0]     used_r, used_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic                 pc_vld_r, pc_vld_nxt;
  logic                 data_vld_r, data_vld_nxt;
  logic                 cnt_req_r, cnt_req_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [IDX_W-1:0]     out_alloc_r, out_alloc_nxt;
  logic [BLK_W-1:0]     out_free_r, out_free_nxt;

  // datapath helpers
  logic [BLK_W-1:0]     eff_total;
  logic [BASE_W-1:0]    eff_base;
  logic [BASE_W-1:0]    ss_base;
  logic [BASE_W-1:0]    start_base;
  logic [BASE_W-1:0]    next_base;
  logic [BASE_W-1:0]    alloc_sum;
  logic [WORD_BITS-1:0] alloc_bit;
  logic [WORD_BITS-1:0] free_bit;
  logic                 in_accept;
  logic                 load_out;
  status_t              res_status;
  logic [IDX_W-1:0]     res_alloc;
  logic [BLK_W-1:0]     res_used;

  bba_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .total_wr (total_wr)
  );

  bba_bitmap_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  bba_word_eval #(
    .WORD_BITS (WORD_BITS)
  ) u_eval (
    .word      (ram_rd_data),
    .base      (chk_base_r),
    .lo_bound  (ev_lo),
    .hi_bound  (eff_base),
    .found     (ev_found),
    .first_pos (ev_pos),
    .set_count (ev_count)
  );

  // Effective total: total_blocks limited to the bitmap size
  assign eff_total  = (cfg.total_blocks > BLK_CAP) ? BLK_CAP : cfg.total_blocks;
  assign eff_base   = BASE_W'(eff_total);
  assign ss_base    = BASE_W'(cfg.search_start);
  assign start_base = (ss_base >> WB_LOG) << WB_LOG;
  assign next_base  = chk_base_r + WORD_STEP;
  assign alloc_sum  = chk_base_r + BASE_W'(ev_pos);
  assign alloc_bit  = WORD_BITS'(1) << ev_pos;
  assign free_bit   = WORD_BITS'(1) << idx_r[WB_LOG-1:0];

  // The search window opens at search_start; a recount covers everything below the total
  assign ev_lo = (state_r == S_SCAN) ? ss_base : '0;

  // Hold off new beats outside idle, while a recount is pending or while the result slot is full and not taken
  assign in_ready  = (state_r == S_IDLE) && !cnt_req_r && !total_wr &&
                     (!out_valid_r || out_ready);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    chk_base_nxt = chk_base_r;
    idx_nxt      = idx_r;
    used_nxt     = used_r;
    pc_nxt       = pc_r;
    pc_vld_nxt   = 1'b0;
    data_vld_nxt = 1'b0;
    cnt_req_nxt  = cnt_req_r;

    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = '0;

    load_out     = 1'b0;
    res_status   = STAT_OK;
    res_alloc    = '0;
    res_used     = used_r;

    case (state_r)
      // Sweep zeros through the whole bitmap after reset
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr_r;
        ram_wr_data = '0;
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (cnt_req_r) begin
          // Total changed: rebuild the used count below the new total
          cnt_req_nxt = 1'b0;
          used_nxt    = '0;
          if (eff_total != '0) begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = word_addr('0);
            chk_base_nxt = '0;
            data_vld_nxt = 1'b1;
            state_nxt    = S_COUNT;
          end
        end else if (in_accept) begin
          if (op_t'(in_operation) == OP_ALLOC) begin
            if (ss_base >= eff_base) begin
              load_out   = 1'b1;
              res_status = STAT_FULL;
            end else begin
              ram_rd_en    = 1'b1;
              ram_rd_addr  = word_addr(start_base);
              chk_base_nxt = start_base;
              state_nxt    = S_SCAN;
            end
          end else begin
            // Bound check before any bitmap access
            if (BLK_W'(in_block_index) >= eff_total) begin
              load_out   = 1'b1;
              res_status = STAT_RANGE;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = word_addr(BASE_W'(in_block_index));
              idx_nxt     = in_block_index;
              state_nxt   = S_FREE;
            end
          end
        end
      end

      // One word a cycle: test the returned word, fetch the next one
      S_SCAN: begin
        if (ev_found) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = word_addr(chk_base_r);
          ram_wr_data = ram_rd_data | alloc_bit;
          load_out    = 1'b1;
          res_status  = STAT_OK;
          res_alloc   = IDX_W'(alloc_sum);
          res_used    = used_r + 1'b1;
          state_nxt   = S_IDLE;
        end else if (next_base < eff_base) begin
          ram_rd_en    = 1'b1;
          ram_rd_addr  = word_addr(next_base);
          chk_base_nxt = next_base;
        end else begin
          load_out   = 1'b1;
          res_status = STAT_FULL;
          state_nxt  = S_IDLE;
        end
      end

      // Clear the bit; drop the count only if it was set
      S_FREE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = word_addr(BASE_W'(idx_r));
        ram_wr_data = ram_rd_data & ~free_bit;
        load_out    = 1'b1;
        res_status  = STAT_OK;
        if (|(ram_rd_data & free_bit)) begin
          res_used = used_r - 1'b1;
        end
        state_nxt = S_IDLE;
      end

      // Read, popcount, accumulate: three-deep pipeline over the bitmap words
      S_COUNT: begin
        if (data_vld_r) begin
          pc_nxt     = ev_count;
          pc_vld_nxt = 1'b1;
          if (next_base < eff_base) begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = word_addr(next_base);
            chk_base_nxt = next_base;
            data_vld_nxt = 1'b1;
          end
        end
        if (pc_vld_r) begin
          used_nxt = used_r + BLK_W'(pc_r);
        end
        if (!data_vld_r && !pc_vld_r) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (total_wr) begin
      cnt_req_nxt = 1'b1;
    end

    // Output register: hold until taken, reload when a result is ready
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_alloc_nxt  = out_alloc_r;
    out_free_nxt   = out_free_r;
    if (load_out) begin
      used_nxt       = res_used;
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_alloc_nxt  = res_alloc;
      out_free_nxt   = eff_total - res_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      used_r      <= '0;
      pc_vld_r    <= 1'b0;
      data_vld_r  <= 1'b0;
      cnt_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      used_r      <= used_nxt;
      pc_vld_r    <= pc_vld_nxt;
      data_vld_r  <= data_vld_nxt;
      cnt_req_r   <= cnt_req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    chk_base_r   <= chk_base_nxt;
    idx_r        <= idx_nxt;
    pc_r         <= pc_nxt;
    out_status_r <= out_status_nxt;
    out_alloc_r  <= out_alloc_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_allocated_block = out_alloc_r;
  assign out_free_blocks     = out_free_r;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int WB     = WORD_BITS_DEF;
  localparam int NWORDS = MAX_BLOCKS_DEF / WB;

  typedef struct packed {
    status_t              status;
    logic [IDX_W-1:0]     block;
    logic [BLK_W-1:0]     free_cnt;
  } alloc_result_t;

  // Mirror of the allocator: occupancy bitmap, used count, registers, and the
  // replies still owed by the block in the order the beats went in.
  class alloc_scoreboard;
    bit [WB-1:0]     words [NWORDS];
    int unsigned     used_cnt;
    int unsigned     start_idx;
    int unsigned     total_cnt;
    alloc_result_t   owed [$];
    int              errors;
    int              n_items;
    int              n_alloc;
    int              n_full;
    int              n_range;

    function new();
      foreach (words[w]) words[w] = '0;
      used_cnt  = 0;
      start_idx = SEARCH_START_RST;
      total_cnt = TOTAL_BLOCKS_RST;
      errors    = 0;
      n_items   = 0;
      n_alloc   = 0;
      n_full    = 0;
      n_range   = 0;
    endfunction

    function int unsigned eff_total();
      return (total_cnt > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : total_cnt;
    endfunction

    function bit bit_at(int unsigned b);
      return words[b / WB][b % WB];
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void write_reg(logic sel, logic [CFG_DW-1:0] val);
      int unsigned tot;
      if (sel == REG_SEARCH_START) begin
        start_idx = val[IDX_W-1:0];
      end else begin
        total_cnt = val[BLK_W-1:0];
      end
      // Bits above a lowered total keep their value but drop out of the count
      tot      = eff_total();
      used_cnt = 0;
      for (int unsigned b = 0; b < tot; b++) used_cnt += bit_at(b);
    endfunction

    function void note_item(op_t op, logic [IDX_W-1:0] idx);
      int unsigned   tot;
      int unsigned   b;
      alloc_result_t r;
      tot      = eff_total();
      r.status = STAT_OK;
      r.block  = '0;
      if (op == OP_ALLOC) begin
        b = start_idx;
        while (b < tot) begin
          if (&words[b / WB]) begin
            b = (b / WB + 1) * WB;   // skip a word with no clear bit
          end else if (bit_at(b)) begin
            b++;
          end else begin
            break;
          end
        end
        if (b >= tot) begin
          r.status = STAT_FULL;
        end else begin
          words[b / WB][b % WB] = 1'b1;
          used_cnt++;
          n_alloc++;
          r.block = IDX_W'(b);
        end
      end else if (idx >= tot) begin
        r.status = STAT_RANGE;
      end else if (bit_at(idx)) begin
        words[idx / WB][idx % WB] = 1'b0;
        used_cnt--;
      end
      r.free_cnt = BLK_W'(tot - used_cnt);
      owed.push_back(r);
      n_items++;
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [1:0] st, logic [IDX_W-1:0] blk,
                               logic [BLK_W-1:0] fr);
      alloc_result_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, status %0d block %0d free %0d",
                 $time, st, blk, fr);
        return;
      end
      e = owed.pop_front();
      compare("status", e.status, st);
      compare("allocated_block", e.block, blk);
      compare("free_blocks", e.free_cnt, fr);
      case (e.status)
        STAT_FULL:  n_full++;
        STAT_RANGE: n_range++;
        default:    ;
      endcase
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_operation;
  logic [IDX_W-1:0]    in_block_index;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_status;
  logic [IDX_W-1:0]    out_allocated_block;
  logic [BLK_W-1:0]    out_free_blocks;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  alloc_scoreboard     sb;

  // Idling knobs, in percent per cycle
  int                  send_idle_pct;
  int                  recv_stall_pct;

  // Long receiver hold-off: the main thread bumps hold_seq, the receiver
  // process counts down hold_len on its own
  int                  hold_seq;
  int                  hold_seen;
  int                  hold_len;
  int                  hold_left;

  bitmap_block_allocator_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_block_index      (in_block_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_allocated_block (out_allocated_block),
    .out_free_blocks     (out_free_blocks),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe both channels on the pre-edge values: note each input beat in the
  // predictor, check each result beat against the oldest reply owed
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(op_t'(in_operation), in_block_index);
      if (out_valid && out_ready) begin
        sb.check_result(out_status, out_allocated_block, out_free_blocks);
      end
    end
  end

  // Result side: random stalls, or a solid hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one beat after an optional random gap; hold it until accepted.
  // valid stays high on return so back-to-back beats need no extra edge.
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_block_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every owed reply has come back; step past
  // the current edge first so the last accepted beat is already noted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write (setup + access), then read it back
  task automatic cfg_write(logic sel, logic [CFG_DW-1:0] val);
    logic [CFG_DW-1:0] mask;
    mask    = (sel == REG_SEARCH_START) ? CFG_DW'((1 << IDX_W) - 1)
                                        : CFG_DW'((1 << BLK_W) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(sel, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.compare("register read-back", val & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Hand-picked beats: defaults, tiny and empty disks, the top block, a start
  // past the total and a total that shrinks under set bits
  task automatic directed();
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '1);
    send_item(OP_FREE, 14'd1024);
    send_item(OP_FREE, 14'd1024);       // already clear: still ok
    send_item(OP_FREE, 14'd0);
    send_item(OP_FREE, 14'd16383);
    send_item(OP_ALLOC, 14'h2AAA);
    drain();
    cfg_write(REG_SEARCH_START, 32'd0);
    cfg_write(REG_TOTAL_BLOCKS, 32'd1);
    send_item(OP_ALLOC, 14'h1555);
    send_item(OP_ALLOC, '0);            // single block taken: disk full
    send_item(OP_FREE, 14'd1);
    send_item(OP_FREE, 14'd0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 14'd16383);
    drain();
    cfg_write(REG_TOTAL_BLOCKS, 32'd0); // nothing covered
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 14'd0);
    drain();
    cfg_write(REG_SEARCH_START, 32'd16383);
    cfg_write(REG_TOTAL_BLOCKS, 32'd16384);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 14'd16383);
    send_item(OP_ALLOC, '1);
    drain();
    cfg_write(REG_SEARCH_START, 32'd200);
    cfg_write(REG_TOTAL_BLOCKS, 32'd100);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 14'd99);
    send_item(OP_FREE, 14'd100);
    drain();
    cfg_write(REG_SEARCH_START, 32'd1024);
    cfg_write(REG_TOTAL_BLOCKS, 32'd1024);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 14'd1024);
    drain();
    cfg_write(REG_TOTAL_BLOCKS, 32'd1025); // set bit comes back into range
    send_item(OP_ALLOC, '0);
    drain();
  endtask

  // One random phase under one register setting and one idling pattern.
  // Frees mostly land inside the disk, the rest past its end or anywhere.
  task automatic run_phase(int start, int total, int n, int alloc_pct,
                           int sidle, int rstall, int hold);
    op_t              op;
    logic [IDX_W-1:0] idx;
    int unsigned      tot;
    int               pick;
    cfg_write(REG_SEARCH_START, start);
    cfg_write(REG_TOTAL_BLOCKS, total);
    send_idle_pct   = sidle;
    recv_stall_pct <= rstall;
    if (hold != 0) begin
      hold_len <= hold;
      hold_seq <= hold_seq + 1;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      tot = sb.eff_total();
      if ($urandom_range(0, 99) < alloc_pct) begin
        op  = OP_ALLOC;
        idx = IDX_W'($urandom);
      end else begin
        op   = OP_FREE;
        pick = $urandom_range(0, 99);
        if (pick < 70 && tot > 0) begin
          idx = IDX_W'($urandom_range(0, tot - 1));
        end else if (pick < 85 && tot < MAX_BLOCKS_DEF) begin
          idx = IDX_W'($urandom_range(tot, MAX_BLOCKS_DEF - 1));
        end else begin
          idx = IDX_W'($urandom);
        end
      end
      send_item(op, idx);
    end
    drain();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = 1'b0;
    in_block_index = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = 0;
    hold_seen      = 0;
    hold_len       = 0;
    hold_left      = 0;
    sb             = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();

    // start, total, items, alloc %, sender idle %, receiver stall %, hold-off
    run_phase(0,     64,    300, 60, 0,  0,  0);
    run_phase(10,    100,   300, 65, 76, 0,  0);
    run_phase(0,     40,    300, 55, 0,  76, 0);
    run_phase(0,     48,    150, 60, 0,  0,  400);  // fill up behind a stalled receiver
    run_phase(30,    200,   300, 60, 34, 34, 0);
    run_phase(16300, 16384, 200, 55, 34, 34, 0);
    run_phase(0,     16384, 200, 70, 0,  0,  0);

    // Let any stray beat surface after the last reply
    repeat (600) @(posedge clk);

    $display("Ran %0d beats: %0d allocations, %0d disk-full and %0d out-of-range replies,",
             sb.n_items, sb.n_alloc, sb.n_full, sb.n_range);
    $display("totals from 0 to 16384 blocks, idle and stall mixes, one long hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[bitmap_block_allocator_top] OK");
    end else begin
      $display("%0d failures, %0d replies still owed", sb.errors, sb.pending());
      $display("[bitmap_block_allocator_top] ERROR");
    end
    $finish;
  end

  // Hard ceiling on run time
  initial begin
    #50_000_000;
    $display("Timed out with %0d replies still owed", sb.pending());
    $display("[bitmap_block_allocator_top] ERROR");
    $finish;
  end

endmodule
